### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sand grid step unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that holds at every clock edge outside reset.
`define FSGS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// A condition that, when seen, forces a consequence in the cycle after it.
`define FSGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fsgs_pkg.sv
// ----------------------------------------------------------------------------
// fsgs_pkg
// Types, constants and helpers shared by the sand grid step unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsgs_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int CFG_W       = 7;
    localparam int CMD_W       = 2;
    localparam int COORD_W     = 6;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    typedef logic [MAX_COLUMNS-1:0] t_row;

    typedef enum logic [CMD_W-1:0] {
        CMD_TOGGLE = 2'd0,
        CMD_STEP   = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef enum logic {
        CFG_COLUMN_COUNT = 1'b0,
        CFG_ROW_COUNT    = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMD_RD,
        S_CMD_WR,
        S_STEP_RD0,
        S_STEP_RD1,
        S_ROW_LOAD,
        S_CELL,
        S_ROW_END,
        S_CLEAR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [CFG_W-1:0] cols;
        logic             bottom;
    } t_cell_ctl;

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] max_v);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > max_v) begin
            r = max_v;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/falling_sand_grid_step_unit.sv
// ----------------------------------------------------------------------------
// falling_sand_grid_step_unit
// Sand grid with toggle, read and generation step commands; one cell is
// evaluated per cycle, rows are buffered in registers and written back in place.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: col_x, row_y; tuser: cmd
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: cell_value; tuser: status
// cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// Toggle and read go through a row read, the update and the result; with
// coordinates outside the grid they go straight to the result.
// A step reads the first two rows, scans and writes back each row in use, then clears
// the rows below the grid in use; the single cell unit handles one cell per cycle.
// Reset is synchronous and leaves the grid empty with no clearing pass.
// A new command or a register write is taken only in idle; a stalled result holds the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module falling_sand_grid_step_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // col_x [5:0], row_y [11:6], zeros above
    input  wire logic [fsgs_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // cmd [1:0]
    input  wire logic [fsgs_pkg::CMD_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // cell_value [0], zeros above
    output logic [fsgs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // status [0]
    output logic [0:0]                         m_axis_tuser,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_index,
    input  wire logic [fsgs_pkg::CFG_W-1:0]     i_cfg_data
);

    fsgs_pkg::t_state              r_state;
    fsgs_pkg::t_state              n_state;
    logic [fsgs_pkg::CFG_W-1:0]    r_cols_cfg;
    logic [fsgs_pkg::CFG_W-1:0]    r_rows_cfg;
    logic [fsgs_pkg::CFG_W-1:0]    cols;
    logic [fsgs_pkg::CFG_W-1:0]    rows;
    logic [fsgs_pkg::CMD_W-1:0]    r_cmd;
    logic [fsgs_pkg::COL_W-1:0]    r_col;
    logic [fsgs_pkg::ROW_W-1:0]    r_row;
    fsgs_pkg::t_row                r_cur_y;
    fsgs_pkg::t_row                r_cur_b;
    fsgs_pkg::t_row                r_nxt_y;
    fsgs_pkg::t_row                r_nxt_b;
    logic                          r_res_value;
    logic                          r_res_status;
    logic                          r_out_valid;
    logic                          r_out_value;
    logic                          r_out_status;

    logic                          s_acc;
    logic                          out_free;
    logic [fsgs_pkg::COORD_W-1:0]  in_x;
    logic [fsgs_pkg::COORD_W-1:0]  in_y;
    logic                          in_oob;
    logic                          in_addr_cmd;
    logic [fsgs_pkg::CFG_W-1:0]    col_ext;
    logic [fsgs_pkg::CFG_W-1:0]    row_ext;
    logic                          last_col;
    logic                          last_row;

    logic                          ram_we;
    logic [fsgs_pkg::ROW_W-1:0]    ram_waddr;
    fsgs_pkg::t_row                ram_wdata;
    logic [fsgs_pkg::ROW_W-1:0]    ram_raddr;
    fsgs_pkg::t_row                ram_rdata;

    fsgs_pkg::t_cell_ctl           cell_ctl;
    fsgs_pkg::t_row                cell_nxt_y;
    fsgs_pkg::t_row                cell_nxt_b;

    assign cols = fsgs_pkg::clamp_size(r_cols_cfg, fsgs_pkg::CFG_W'(fsgs_pkg::MAX_COLUMNS));
    assign rows = fsgs_pkg::clamp_size(r_rows_cfg, fsgs_pkg::CFG_W'(fsgs_pkg::MAX_ROWS));

    assign s_acc       = s_axis_tvalid && s_axis_tready;
    assign out_free    = !r_out_valid || m_axis_tready;
    assign in_x        = s_axis_tdata[fsgs_pkg::COORD_W-1:0];
    assign in_y        = s_axis_tdata[2*fsgs_pkg::COORD_W-1:fsgs_pkg::COORD_W];
    assign in_oob      = (fsgs_pkg::CFG_W'(in_x) >= cols) || (fsgs_pkg::CFG_W'(in_y) >= rows);
    assign in_addr_cmd = (s_axis_tuser == fsgs_pkg::CMD_TOGGLE)
                      || (s_axis_tuser == fsgs_pkg::CMD_READ);
    assign col_ext     = fsgs_pkg::CFG_W'(r_col);
    assign row_ext     = fsgs_pkg::CFG_W'(r_row);
    assign last_col    = col_ext == (cols - fsgs_pkg::CFG_W'(1));
    assign last_row    = row_ext == (rows - fsgs_pkg::CFG_W'(1));

    assign cell_ctl.col    = r_col;
    assign cell_ctl.cols   = cols;
    assign cell_ctl.bottom = last_row;

    fsgs_row_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fsgs_cell_unit u_cell (
        .i_ctl   (cell_ctl),
        .i_cur_y (r_cur_y),
        .i_cur_b (r_cur_b),
        .i_nxt_y (r_nxt_y),
        .i_nxt_b (r_nxt_b),
        .o_nxt_y (cell_nxt_y),
        .o_nxt_b (cell_nxt_b)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            fsgs_pkg::S_IDLE: begin
                if (s_acc) begin
                    if (s_axis_tuser == fsgs_pkg::CMD_STEP) begin
                        n_state = fsgs_pkg::S_STEP_RD0;
                    end else if (in_addr_cmd && !in_oob) begin
                        n_state = fsgs_pkg::S_CMD_RD;
                    end else begin
                        n_state = fsgs_pkg::S_DONE;
                    end
                end
            end
            fsgs_pkg::S_CMD_RD:   n_state = fsgs_pkg::S_CMD_WR;
            fsgs_pkg::S_CMD_WR:   n_state = fsgs_pkg::S_DONE;
            fsgs_pkg::S_STEP_RD0: n_state = fsgs_pkg::S_STEP_RD1;
            fsgs_pkg::S_STEP_RD1: n_state = fsgs_pkg::S_ROW_LOAD;
            fsgs_pkg::S_ROW_LOAD: n_state = fsgs_pkg::S_CELL;
            fsgs_pkg::S_CELL: begin
                if (last_col) begin
                    n_state = fsgs_pkg::S_ROW_END;
                end
            end
            fsgs_pkg::S_ROW_END: begin
                if (!last_row) begin
                    n_state = fsgs_pkg::S_ROW_LOAD;
                end else if (r_row == fsgs_pkg::ROW_W'(fsgs_pkg::MAX_ROWS - 1)) begin
                    n_state = fsgs_pkg::S_DONE;
                end else begin
                    n_state = fsgs_pkg::S_CLEAR;
                end
            end
            fsgs_pkg::S_CLEAR: begin
                if (r_row == fsgs_pkg::ROW_W'(fsgs_pkg::MAX_ROWS - 1)) begin
                    n_state = fsgs_pkg::S_DONE;
                end
            end
            fsgs_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = fsgs_pkg::S_IDLE;
                end
            end
            default: n_state = fsgs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_row;
        ram_wdata     = '0;
        ram_raddr     = r_row;
        case (r_state)
            fsgs_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            fsgs_pkg::S_CMD_WR: begin
                ram_we    = (r_cmd == fsgs_pkg::CMD_TOGGLE);
                ram_wdata = ram_rdata;
                ram_wdata[r_col] = ~ram_rdata[r_col];
            end
            fsgs_pkg::S_STEP_RD0: begin
                ram_raddr = '0;
            end
            fsgs_pkg::S_STEP_RD1: begin
                ram_raddr = fsgs_pkg::ROW_W'(1);
            end
            fsgs_pkg::S_ROW_END: begin
                ram_we    = 1'b1;
                ram_wdata = r_nxt_y;
                ram_raddr = r_row + fsgs_pkg::ROW_W'(2);
            end
            fsgs_pkg::S_CLEAR: begin
                ram_we = 1'b1;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsgs_pkg::S_IDLE;
            r_cols_cfg  <= fsgs_pkg::CFG_W'(fsgs_pkg::MAX_COLUMNS);
            r_rows_cfg  <= fsgs_pkg::CFG_W'(fsgs_pkg::MAX_ROWS);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    fsgs_pkg::CFG_COLUMN_COUNT: r_cols_cfg <= i_cfg_data;
                    fsgs_pkg::CFG_ROW_COUNT:    r_rows_cfg <= i_cfg_data;
                    default:                    r_cols_cfg <= r_cols_cfg;
                endcase
            end
            if (r_state == fsgs_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            fsgs_pkg::S_IDLE: begin
                if (s_acc) begin
                    r_cmd        <= s_axis_tuser;
                    r_col        <= fsgs_pkg::COL_W'(in_x);
                    r_row        <= fsgs_pkg::ROW_W'(in_y);
                    r_res_value  <= 1'b0;
                    r_res_status <= in_oob && in_addr_cmd;
                end
            end
            fsgs_pkg::S_CMD_WR: begin
                r_res_value <= ram_rdata[r_col] ^ (r_cmd == fsgs_pkg::CMD_TOGGLE);
            end
            fsgs_pkg::S_STEP_RD0: begin
                r_nxt_y <= '0;
                r_nxt_b <= '0;
                r_row   <= '0;
            end
            fsgs_pkg::S_STEP_RD1: begin
                r_cur_y <= ram_rdata;
            end
            fsgs_pkg::S_ROW_LOAD: begin
                r_cur_b <= ram_rdata;
                r_col   <= '0;
            end
            fsgs_pkg::S_CELL: begin
                r_nxt_y <= cell_nxt_y;
                r_nxt_b <= cell_nxt_b;
                r_col   <= r_col + fsgs_pkg::COL_W'(1);
            end
            fsgs_pkg::S_ROW_END: begin
                r_cur_y <= r_cur_b;
                r_nxt_y <= r_nxt_b;
                r_nxt_b <= '0;
                r_row   <= r_row + fsgs_pkg::ROW_W'(1);
            end
            fsgs_pkg::S_CLEAR: begin
                r_row <= r_row + fsgs_pkg::ROW_W'(1);
            end
            fsgs_pkg::S_DONE: begin
                if (out_free) begin
                    r_out_value  <= r_res_value;
                    r_out_status <= r_res_status;
                end
            end
            default: begin
                r_row <= r_row;
            end
        endcase
    end

    assign o_cfg_ready   = (r_state == fsgs_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = fsgs_pkg::M_TDATA_W'(r_out_value);
    assign m_axis_tuser  = r_out_status;

    `FSGS_ASSERT_NEXT(a_busy_after_accept, s_acc, !s_axis_tready,
        "input accepted but block still ready in the next cycle")
    `FSGS_ASSERT(a_scan_col_in_grid, (r_state != fsgs_pkg::S_CELL) || (col_ext < cols),
        "cell scan column outside the grid in use")
    `FSGS_ASSERT(a_scan_row_in_grid, (r_state != fsgs_pkg::S_CELL) || (row_ext < rows),
        "cell scan row outside the grid in use")
    `FSGS_ASSERT(a_status_zero_value, !(r_out_valid && r_out_status) || !r_out_value,
        "result flagged out of range carries a cell value")
    `FSGS_ASSERT_NEXT(a_done_holds, (r_state == fsgs_pkg::S_DONE) && !out_free,
        r_state == fsgs_pkg::S_DONE, "completion left while the result register is full")

endmodule

`default_nettype wire

### rtl/fsgs_row_ram.sv
// ----------------------------------------------------------------------------
// fsgs_row_ram
// Grid storage, one row per word, with per-row valid bits so that rows never
// written since reset read as empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsgs_row_ram (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_we,
    input  wire logic [fsgs_pkg::ROW_W-1:0] i_waddr,
    input  wire fsgs_pkg::t_row            i_wdata,
    input  wire logic [fsgs_pkg::ROW_W-1:0] i_raddr,
    output fsgs_pkg::t_row                 o_rdata
);

    fsgs_pkg::t_row                    mem [fsgs_pkg::MAX_ROWS];
    logic [fsgs_pkg::MAX_ROWS-1:0]     r_valid;
    fsgs_pkg::t_row                    r_rdata;
    logic                              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

`default_nettype wire

### rtl/fsgs_cell_unit.sv
// ----------------------------------------------------------------------------
// fsgs_cell_unit
// Decides where the grain of one cell goes and updates the two rows of the
// generation under construction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsgs_cell_unit (
    input  wire fsgs_pkg::t_cell_ctl i_ctl,
    input  wire fsgs_pkg::t_row      i_cur_y,
    input  wire fsgs_pkg::t_row      i_cur_b,
    input  wire fsgs_pkg::t_row      i_nxt_y,
    input  wire fsgs_pkg::t_row      i_nxt_b,
    output fsgs_pkg::t_row           o_nxt_y,
    output fsgs_pkg::t_row           o_nxt_b
);

    logic [fsgs_pkg::COL_W-1:0] x;
    logic [fsgs_pkg::COL_W-1:0] xr;
    logic [fsgs_pkg::COL_W-1:0] xl;
    logic                       free_b;
    logic                       free_r;
    logic                       free_l;

    always_comb begin
        x  = i_ctl.col;
        xr = ((fsgs_pkg::CFG_W'(x) + fsgs_pkg::CFG_W'(1)) < i_ctl.cols)
             ? x + fsgs_pkg::COL_W'(1) : x;
        xl = (x != '0) ? x - fsgs_pkg::COL_W'(1) : x;

        free_b = !i_cur_b[x]  && !i_nxt_b[x];
        free_r = !i_cur_b[xr] && !i_nxt_b[xr];
        free_l = !i_cur_b[xl] && !i_nxt_b[xl];

        o_nxt_y = i_nxt_y;
        o_nxt_b = i_nxt_b;
        if (i_cur_y[x]) begin
            if (i_ctl.bottom) begin
                o_nxt_y[x] = 1'b1;
            end else if (free_b) begin
                o_nxt_b[x] = 1'b1;
            end else if (free_r) begin
                o_nxt_b[xr] = 1'b1;
            end else if (free_l) begin
                o_nxt_b[xl] = 1'b1;
            end else begin
                o_nxt_y[x] = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### dv/falling_sand_grid_step_unit_tb.sv
// ----------------------------------------------------------------------------
// falling_sand_grid_step_unit_tb
// Drives toggle, read, step and unused commands into the sand grid unit under
// several grid sizes and checks every result against a cell-level model of the
// grid or against a value given in the directed table. The directed table comes
// first, followed by random phases with bursty input and a stalling result receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module falling_sand_grid_step_unit_tb;

    import fsgs_pkg::*;

    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 15;

    typedef struct packed {
        logic             is_cfg;
        logic             reg_idx;
        logic [CFG_W-1:0] reg_val;
        logic [CMD_W-1:0] cmd;
        logic [5:0]       col;
        logic [5:0]       row;
        logic             typed;
        logic             exp_value;
        logic             exp_status;
    } dir_entry_t;

    typedef struct packed {
        logic value;
        logic status;
    } cell_reply_t;

    typedef struct packed {
        logic        typed;
        cell_reply_t reply;
    } typed_reply_t;

    localparam int DIR_N = 27;
    localparam dir_entry_t DIRECTED [DIR_N] = '{
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_READ,   6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_READ,   6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_TOGGLE, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_TOGGLE, 6'd0,  6'd0,  1'b1, 1'b1, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_TOGGLE, 6'd63, 6'd0,  1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_TOGGLE, 6'd63, 6'd1,  1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_TOGGLE, 6'd0,  6'd1,  1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_TOGGLE, 6'd1,  6'd1,  1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_STEP,   6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_READ,   6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_READ,   6'd62, 6'd1,  1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_READ,   6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_UNUSED, 6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
        '{1'b1, CFG_COLUMN_COUNT, 7'd0,   CMD_READ,   6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{1'b1, CFG_ROW_COUNT,    7'd127, CMD_READ,   6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_TOGGLE, 6'd1,  6'd0,  1'b1, 1'b0, 1'b1},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_READ,   6'd0,  6'd63, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_STEP,   6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
        '{1'b1, CFG_COLUMN_COUNT, 7'd64,  CMD_READ,   6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_READ,   6'd62, 6'd1,  1'b0, 1'b0, 1'b0},
        '{1'b1, CFG_ROW_COUNT,    7'd1,   CMD_READ,   6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_READ,   6'd0,  6'd1,  1'b1, 1'b0, 1'b1},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_READ,   6'd63, 6'd63, 1'b1, 1'b0, 1'b1},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_TOGGLE, 6'd5,  6'd0,  1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_STEP,   6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_READ,   6'd5,  6'd0,  1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_COLUMN_COUNT, 7'd0,   CMD_READ,   6'd63, 6'd0,  1'b0, 1'b0, 1'b0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic                  i_cfg_index = 1'b0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    bit                    grid_now [CELLS];
    bit                    grid_next [CELLS];
    logic [CFG_W-1:0]      model_cols = 7'd64;
    logic [CFG_W-1:0]      model_rows = 7'd64;
    cell_reply_t           expected_replies [$];
    typed_reply_t          typed_replies [$];
    int                    mismatches = 0;
    int                    burst_left = 0;
    int                    stall_left = 0;
    int unsigned           ready_tick = 0;

    falling_sand_grid_step_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int grid_size(input logic [CFG_W-1:0] v, input int max_v);
        int r;
        if (v == '0) begin
            r = 1;
        end else if (int'(v) > max_v) begin
            r = max_v;
        end else begin
            r = int'(v);
        end
        return r;
    endfunction

    function automatic bit cell_free(input int idx);
        return !grid_now[idx] && !grid_next[idx];
    endfunction

    task automatic settle_sand(input int cols, input int rows);
        int here;
        int below;
        int right;
        int left;
        for (int i = 0; i < CELLS; i++) begin
            grid_next[i] = 1'b0;
        end
        for (int y = 0; y < rows; y++) begin
            for (int x = 0; x < cols; x++) begin
                here = y * MAX_COLUMNS + x;
                if (grid_now[here]) begin
                    if (y + 1 >= rows) begin
                        grid_next[here] = 1'b1;
                    end else begin
                        below = here + MAX_COLUMNS;
                        right = (x + 1 < cols) ? below + 1 : below;
                        left  = (x > 0) ? below - 1 : below;
                        if (cell_free(below)) begin
                            grid_next[below] = 1'b1;
                        end else if (cell_free(right)) begin
                            grid_next[right] = 1'b1;
                        end else if (cell_free(left)) begin
                            grid_next[left] = 1'b1;
                        end else begin
                            grid_next[here] = 1'b1;
                        end
                    end
                end
            end
        end
        for (int i = 0; i < CELLS; i++) begin
            grid_now[i] = grid_next[i];
        end
    endtask

    task automatic predict_reply(input logic [CMD_W-1:0] cmd, input logic [5:0] x,
                                 input logic [5:0] y, output cell_reply_t rep);
        int cols;
        int rows;
        int idx;
        cols = grid_size(model_cols, MAX_COLUMNS);
        rows = grid_size(model_rows, MAX_ROWS);
        rep  = '0;
        if (cmd == CMD_STEP) begin
            settle_sand(cols, rows);
        end else if (cmd == CMD_TOGGLE || cmd == CMD_READ) begin
            if (int'(x) >= cols || int'(y) >= rows) begin
                rep.status = 1'b1;
            end else begin
                idx = int'(y) * MAX_COLUMNS + int'(x);
                if (cmd == CMD_TOGGLE) begin
                    grid_now[idx] = ~grid_now[idx];
                end
                rep.value = grid_now[idx];
            end
        end
    endtask

    // Results are checked before new commands are predicted, so a result and a
    // command accepted on the same edge are kept in order.
    always @(posedge i_clk) begin : monitor
        cell_reply_t  want;
        cell_reply_t  pred;
        typed_reply_t ovr;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected result transaction: cell_value %0d status %0d",
                             $time, m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end else begin
                    want = expected_replies.pop_front();
                    if (m_axis_tdata != M_TDATA_W'(want.value)) begin
                        $display("%0t: cell_value expected %0d actual %0d",
                                 $time, want.value, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tuser[0] != want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_axis_tuser[0]);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_reply(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[11:6], pred);
                ovr = typed_replies.pop_front();
                expected_replies.push_back(ovr.typed ? ovr.reply : pred);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_COLUMN_COUNT) begin
                    model_cols = i_cfg_data;
                end else begin
                    model_rows = i_cfg_data;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        ready_tick <= ready_tick + 1;
        if (ready_tick[9:8] == 2'd0) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [5:0] x,
                                input logic [5:0] y, input logic typed,
                                input cell_reply_t reply);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left = burst_left - 1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, y, x};
        s_axis_tuser  <= cmd;
        typed_replies.push_back({typed, reply});
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained;
        @(posedge i_clk);
        while (expected_replies.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_grid_reg(input logic idx, input logic [CFG_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] c_val;
        logic [CFG_W-1:0] r_val;
        logic [CMD_W-1:0] cmd;
        logic [5:0]       x;
        logic [5:0]       y;
        int               pick;
        int               cols_e;
        int               rows_e;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            if (DIRECTED[i].is_cfg) begin
                write_grid_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
            end else begin
                send_command(DIRECTED[i].cmd, DIRECTED[i].col, DIRECTED[i].row,
                             DIRECTED[i].typed,
                             {DIRECTED[i].exp_value, DIRECTED[i].exp_status});
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    c_val = 7'd0;
                    r_val = 7'd0;
                end
                1: begin
                    c_val = 7'd127;
                    r_val = 7'd3;
                end
                2: begin
                    c_val = 7'd5;
                    r_val = 7'd127;
                end
                3: begin
                    c_val = 7'd64;
                    r_val = 7'd64;
                end
                4: begin
                    c_val = 7'($urandom_range(65, 127));
                    r_val = 7'($urandom_range(1, 8));
                end
                default: begin
                    c_val = 7'($urandom_range(1, 12));
                    r_val = 7'($urandom_range(1, 12));
                end
            endcase
            write_grid_reg(CFG_COLUMN_COUNT, c_val);
            write_grid_reg(CFG_ROW_COUNT, r_val);
            cols_e = grid_size(c_val, MAX_COLUMNS);
            rows_e = grid_size(r_val, MAX_ROWS);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    cmd = CMD_TOGGLE;
                end else if (pick < 72) begin
                    cmd = CMD_READ;
                end else if (pick < 96) begin
                    cmd = CMD_STEP;
                end else begin
                    cmd = CMD_UNUSED;
                end
                if ($urandom_range(0, 9) == 0) begin
                    x = 6'($urandom_range(0, 63));
                    y = 6'($urandom_range(0, 63));
                end else begin
                    x = 6'($urandom_range(0, cols_e - 1));
                    y = 6'($urandom_range(0, rows_e - 1));
                end
                send_command(cmd, x, y, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[falling_sand_grid_step_unit] OK");
        end else begin
            $display("[falling_sand_grid_step_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[falling_sand_grid_step_unit] ERROR");
        $finish;
    end

endmodule
